// ===== rtl/core/bspa_pkg.sv =====
// Package for the bitmap slot pool allocator: sizes, command and status
// codes, controller states, control struct and priority search functions.
// No dependencies.
`default_nettype none

package bspa_pkg;

  // Pool geometry
  localparam int NUM_BLOCKS      = 16;
  localparam int SLOTS_PER_BLOCK = 64;
  localparam int BLOCK_W         = 4;
  localparam int BIT_W           = 6;
  localparam int SLOT_W          = BLOCK_W + BIT_W;
  // Blocks reachable through the slot number field
  localparam int FIELD_BLOCKS    = 1 << BLOCK_W;
  localparam int LIVE_BLOCKS     = (NUM_BLOCKS < FIELD_BLOCKS) ? NUM_BLOCKS : FIELD_BLOCKS;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  typedef logic [SLOTS_PER_BLOCK-1:0] word_t;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_LIVE = 2'd2,
    ST_UNUSED   = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_UPDATE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;   // latch the transaction and start the bitmap read
    logic commit;   // write back the bitmap and load the result register
  } ctrl_t;

  // Index of the lowest clear bit of a bitmap word
  function automatic logic [BIT_W-1:0] lowest_clear(input word_t w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = SLOTS_PER_BLOCK - 1; i >= 0; i--) begin
      if (!w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  // Index of the lowest block whose full flag is clear
  function automatic logic [BLOCK_W-1:0] lowest_open(input logic [NUM_BLOCKS-1:0] f);
    logic [BLOCK_W-1:0] idx;
    idx = '0;
    for (int i = LIVE_BLOCKS - 1; i >= 0; i--) begin
      if (!f[i]) idx = BLOCK_W'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bitmap_slot_pool_allocator.sv =====
// Bitmap slot pool allocator: 16 blocks of 64 slots, allocate lowest free
// slot, free a slot, clear the pool. Each command gives one result.
// Accept latches the transaction and reads its bitmap word; commit writes
// the word back and loads the result register once that register is free.
// Commands wait for the previous commit; a held result stalls the write-back.
// Reset (synchronous, active high) empties the pool at once through the
// per-block flags; no clearing pass. Depends on bspa_pkg, bspa_ctrl, bspa_dpath.
`default_nettype none

module bitmap_slot_pool_allocator
  import bspa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [1:0] cmd, [11:2] slot_index, rest zero
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [OUT_DATA_W-1:0] m_tdata    // [9:0] slot_out, [11:10] status,
                                                // [12] block_emptied, rest zero
);

  ctrl_t ctrl;

  bspa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .ctrl     (ctrl)
  );

  bspa_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .in_data  (s_tdata),
    .out_data (m_tdata)
  );

endmodule

`default_nettype wire

// ===== rtl/core/bspa_ctrl.sv =====
// Controller for the bitmap slot pool allocator: two-state sequencer and
// result valid register. Depends on bspa_pkg.
`default_nettype none

module bspa_ctrl
  import bspa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  wire logic  m_tready,
  output ctrl_t      ctrl
);

  state_t state, state_next;
  logic   out_valid, out_valid_next;

  // State and result valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    s_tready       = 1'b0;
    ctrl           = '0;
    if (out_valid && m_tready) out_valid_next = 1'b0;
    case (state)
      S_IDLE: begin
        // refuse transactions while reset is held
        if (!rst) begin
          s_tready    = 1'b1;
          ctrl.accept = s_tvalid;
          if (s_tvalid) state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        // hold until the result register is free
        if (!out_valid || m_tready) begin
          ctrl.commit    = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign m_tvalid = out_valid;

endmodule

`default_nettype wire

// ===== rtl/core/bspa_dpath.sv =====
// Datapath for the bitmap slot pool allocator: bitmap memory, per-block
// full and occupied flags, bit search, update and result register.
// Depends on bspa_pkg.
`default_nettype none

module bspa_dpath
  import bspa_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire ctrl_t                  ctrl,
  input  wire logic [IN_DATA_W-1:0]   in_data,
  output logic      [OUT_DATA_W-1:0]  out_data
);

  // Bitmap memory; an entry is meaningful only while its block is occupied
  word_t mem [NUM_BLOCKS];

  logic [NUM_BLOCKS-1:0] full, full_next;
  logic [NUM_BLOCKS-1:0] occupied, occupied_next;

  // Transaction held between accept and commit
  cmd_t               cmd;
  logic [SLOT_W-1:0]  slot;
  logic [BLOCK_W-1:0] blk;
  logic               none_open;
  word_t              rdata;

  // Result register
  logic [SLOT_W-1:0]  res_slot;
  status_t            res_status;
  logic               res_emptied;

  cmd_t               in_cmd;
  logic [SLOT_W-1:0]  in_slot;
  logic [BLOCK_W-1:0] sel_blk;

  word_t              cur_word;
  word_t              new_word;
  logic [BIT_W-1:0]   bit_pos;
  logic               do_write;
  logic [SLOT_W-1:0]  slot_val;
  status_t            status_val;
  logic               emptied_val;

  assign in_cmd  = cmd_t'(in_data[1:0]);
  assign in_slot = in_data[SLOT_W+1:2];

  // Pick the block: lowest open block for allocate, the slot's block otherwise
  always_comb begin
    if (in_cmd == CMD_ALLOC) sel_blk = lowest_open(full);
    else                     sel_blk = in_slot[SLOT_W-1:BIT_W];
  end

  // Latch the transaction and read the bitmap word
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      cmd       <= in_cmd;
      slot      <= in_slot;
      blk       <= sel_blk;
      none_open <= &full[LIVE_BLOCKS-1:0];
      rdata     <= mem[sel_blk];
    end
  end

  // Compute the new word and the result
  always_comb begin
    cur_word      = occupied[blk] ? rdata : '0;
    new_word      = cur_word;
    bit_pos       = '0;
    do_write      = 1'b0;
    slot_val      = '0;
    status_val    = ST_OK;
    emptied_val   = 1'b0;
    full_next     = full;
    occupied_next = occupied;
    case (cmd)
      CMD_ALLOC: begin
        if (none_open) begin
          status_val = ST_FULL;
        end else begin
          bit_pos            = lowest_clear(cur_word);
          new_word           = cur_word | (word_t'(1) << bit_pos);
          do_write           = 1'b1;
          slot_val           = {blk, bit_pos};
          occupied_next[blk] = 1'b1;
          full_next[blk]     = &new_word;
        end
      end
      CMD_FREE: begin
        bit_pos  = slot[BIT_W-1:0];
        slot_val = slot;
        if (({1'b0, blk} >= (BLOCK_W+1)'(LIVE_BLOCKS)) || !occupied[blk]) begin
          status_val = ST_NOT_LIVE;
        end else begin
          new_word           = cur_word & ~(word_t'(1) << bit_pos);
          do_write           = 1'b1;
          emptied_val        = ~|new_word;
          occupied_next[blk] = |new_word;
          full_next[blk]     = 1'b0;
        end
      end
      CMD_CLEAR: begin
        full_next     = '0;
        occupied_next = '0;
      end
      default: ;
    endcase
  end

  // Flags
  always_ff @(posedge clk) begin
    if (rst) begin
      full     <= '0;
      occupied <= '0;
    end else if (ctrl.commit) begin
      full     <= full_next;
      occupied <= occupied_next;
    end
  end

  // Write back the bitmap word
  always_ff @(posedge clk) begin
    if (ctrl.commit && do_write) mem[blk] <= new_word;
  end

  // Load the result
  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      res_slot    <= slot_val;
      res_status  <= status_val;
      res_emptied <= emptied_val;
    end
  end

  assign out_data = {{(OUT_DATA_W-SLOT_W-3){1'b0}}, res_emptied, res_status, res_slot};

endmodule

`default_nettype wire
